@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // result of the shared key comparator
    typedef struct packed {
        logic lt;   // search key below stored entry (signed)
        logic eq;   // search key equals stored entry
    } cmp_res_t;

endpackage

@@ design/spq_if.sv @@
// ----------------------------------------------------------------------------
// spq_in_if / spq_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface spq_in_if
    import spq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface spq_out_if
    import spq_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] head_value;
    logic                    head_valid;
    logic [COUNT_W-1:0]      count;

    modport source (output valid, output status, output head_value, output head_valid,
                    output count, input ready);
    modport sink   (input valid, input status, input head_value, input head_valid,
                    input count, output ready);
endinterface

@@ design/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/spq_cmp.sv @@
// ----------------------------------------------------------------------------
// spq_cmp
// Shared key comparator: signed less-than and equality.
// ----------------------------------------------------------------------------
module spq_cmp
    import spq_pkg::*;
(
    input  logic [KEY_W-1:0] key,
    input  logic [KEY_W-1:0] entry,
    output cmp_res_t         res
);

    assign res.lt = $signed(key) < $signed(entry);
    assign res.eq = key == entry;

endmodule

@@ design/sorted_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded sorted multiset of signed keys with insert, remove and find.
// ----------------------------------------------------------------------------
// The queue keeps up to CAPACITY keys in ascending order in one RAM, and a
// small sequencer walks that RAM through its single read port with one shared
// comparator, one entry at a time. An insert moves every larger key up one
// slot from the tail, key by key. A find scans from the head. A remove scans
// the same way and then moves the tail down, key by key. The sequencer goes
// back to idle through a response state, which waits until the output register
// is free, before the next command beat is taken.
// The block takes one command at a time; a finished result sits in the output
// register while the next command is accepted. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    spq_in_if.sink      item,
    spq_out_if.source   result
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = CW + COUNT_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [KEY_W-1:0]     head_reg, head_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [KEY_W-1:0]     out_head_reg, out_head_next;
    logic                 out_hvalid_reg, out_hvalid_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_W-1:0]     wr_data;
    logic [AW-1:0]        rd_addr;
    logic [KEY_W-1:0]     rd_data;
    cmp_res_t             cmp;

    logic [CW-1:0]        idx_inc;
    logic [CW-1:0]        idx_dec;
    logic [EXT_W-1:0]     count_ext;

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_dec   = idx_reg - 1'b1;
    assign count_ext = {{COUNT_W{1'b0}}, count_reg};

    spq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    spq_cmp u_cmp (
        .key   (key_reg),
        .entry (rd_data),
        .res   (cmp)
    );

    assign item.ready        = state_reg == S_IDLE;
    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.head_value = out_head_reg;
    assign result.head_valid = out_hvalid_reg;
    assign result.count      = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_head_next   = out_head_reg;
        out_hvalid_next = out_hvalid_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = key_reg;
        rd_addr         = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    cmd_next = item.cmd;
                    key_next = item.value;
                    idx_next = '0;
                    priority if (item.cmd == CMD_INSERT)
                    begin
                        if (count_reg >= CAP_C)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_INS_RD;
                        end
                    end
                    else if (item.cmd == CMD_REMOVE || item.cmd == CMD_FIND)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end
            end

            S_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    // reached the head slot
                    wr_en       = 1'b1;
                    head_next   = key_reg;
                    count_next  = count_reg + 1'b1;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_addr    = idx_dec[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (cmp.lt)
                begin
                    // move the larger key up one slot
                    wr_data    = rd_data;
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next  = count_reg + 1'b1;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
            end

            S_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (cmp.eq)
                begin
                    if (cmd_reg == CMD_FIND)
                    begin
                        status_next = ST_OK;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SHF_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SCAN_RD;
                end
            end

            S_SHF_RD:
            begin
                if (idx_inc >= count_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                end
                else
                begin
                    rd_addr    = idx_inc[AW-1:0];
                    state_next = S_SHF_WR;
                end
            end

            S_SHF_WR:
            begin
                // pull the next key down one slot
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (idx_reg == '0)
                begin
                    head_next = rd_data;
                end
                idx_next   = idx_inc;
                state_next = S_SHF_RD;
            end

            S_RESP:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_hvalid_next = count_reg != '0;
                    out_head_next   = (count_reg != '0) ? head_reg : '0;
                    out_count_next  = count_ext[COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_head_reg   <= '0;
            out_hvalid_reg <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_head_reg   <= out_head_next;
            out_hvalid_reg <= out_hvalid_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        head_reg   <= head_next;
        status_reg <= status_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("command beat taken while a command is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && status_reg == ST_FULL) |-> count_reg == CAP_C)
        else $error("insert dropped while the store had room");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("count changed without a command in progress");

endmodule
